/* rtl/alist_pkg.sv */
// alist_pkg: shared constants, types and operation codes for the array list engine
// no dependencies; used by alist_ctrl and array_list_engine
package alist_pkg;

    localparam int CAPACITY = 128;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 8;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int WORD_W   = 32;
    localparam int MODE_W   = 3;
    localparam int STAT_W   = 2;
    localparam int LEN_W    = 8;

    typedef logic [ADDR_W-1:0]        t_addr;
    typedef logic [CNT_W-1:0]         t_cnt;
    typedef logic [CMP_W-1:0]         t_cmp;
    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic [MODE_W-1:0]        t_mode;
    typedef logic [POS_W-1:0]         t_pos;
    typedef logic [STAT_W-1:0]        t_status;
    typedef logic [LEN_W-1:0]         t_len;

    localparam t_mode MODE_APPEND = 3'd0;
    localparam t_mode MODE_FIND   = 3'd1;
    localparam t_mode MODE_DROP   = 3'd2;
    localparam t_mode MODE_UPDATE = 3'd3;
    localparam t_mode MODE_INSERT = 3'd4;
    localparam t_mode MODE_REMOVE = 3'd5;

    localparam t_status STAT_OK     = 2'd0;
    localparam t_status STAT_FULL   = 2'd1;
    localparam t_status STAT_EMPTY  = 2'd2;
    localparam t_status STAT_BADIDX = 2'd3;

    typedef struct packed {
        t_status status;
        logic    found;
        t_len    length;
    } t_result;

endpackage

/* rtl/alist_ram.sv */
// alist_ram: generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
module alist_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                                            i_clk,
    input  logic                                            i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    i_waddr,
    input  logic [WIDTH-1:0]                                i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    i_raddr,
    output logic [WIDTH-1:0]                                o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* rtl/alist_ctrl.sv */
// alist_ctrl: operation sequencer; decodes an item, walks the entry ram for find and shifts
// depends on alist_pkg; drives the ports of one alist_ram
module alist_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_item_vld,
    output logic                     o_item_rdy,
    input  alist_pkg::t_mode         i_mode,
    input  alist_pkg::t_word         i_value,
    input  alist_pkg::t_pos          i_position,
    output logic                     o_res_vld,
    input  logic                     i_res_rdy,
    output alist_pkg::t_result       o_res,
    output logic                     o_ram_we,
    output alist_pkg::t_addr         o_ram_waddr,
    output alist_pkg::t_word         o_ram_wdata,
    output alist_pkg::t_addr         o_ram_raddr,
    input  alist_pkg::t_word         i_ram_rdata
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_EXEC   = 2'd1;
    localparam logic [1:0] ST_WALK   = 2'd2;
    localparam logic [1:0] ST_RESULT = 2'd3;

    logic [1:0]         r_state, n_state;
    alist_pkg::t_mode   r_mode, n_mode;
    alist_pkg::t_word   r_val, n_val;
    alist_pkg::t_pos    r_pos, n_pos;
    alist_pkg::t_cnt    r_count, n_count;
    alist_pkg::t_addr   r_rd, n_rd;
    alist_pkg::t_addr   r_wa, n_wa;
    alist_pkg::t_cnt    r_left, n_left;
    logic               r_pend, n_pend;
    logic               r_found, n_found;
    alist_pkg::t_status r_status, n_status;

    alist_pkg::t_cmp    cnt_x;
    alist_pkg::t_cmp    pos_x;
    logic               is_full;
    logic               is_empty;
    logic               issue;

    assign cnt_x    = alist_pkg::t_cmp'(r_count);
    assign pos_x    = alist_pkg::t_cmp'(r_pos);
    assign is_full  = (r_count == alist_pkg::t_cnt'(alist_pkg::CAPACITY));
    assign is_empty = (r_count == '0);
    assign issue    = (r_left != '0);

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_val       = r_val;
        n_pos       = r_pos;
        n_count     = r_count;
        n_rd        = r_rd;
        n_wa        = r_wa;
        n_left      = r_left;
        n_pend      = r_pend;
        n_found     = r_found;
        n_status    = r_status;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_wa;
        o_ram_wdata = r_val;
        o_ram_raddr = r_rd;
        case (r_state)
            ST_IDLE: begin
                if (i_item_vld) begin
                    n_mode  = i_mode;
                    n_val   = i_value;
                    n_pos   = i_position;
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_status = alist_pkg::STAT_OK;
                n_found  = 1'b0;
                n_pend   = 1'b0;
                n_state  = ST_RESULT;
                case (r_mode)
                    alist_pkg::MODE_APPEND: begin
                        if (is_full) begin
                            n_status = alist_pkg::STAT_FULL;
                        end else begin
                            o_ram_we    = 1'b1;
                            o_ram_waddr = alist_pkg::t_addr'(r_count);
                            n_count     = r_count + 1'b1;
                        end
                    end
                    alist_pkg::MODE_FIND: begin
                        n_rd    = '0;
                        n_left  = r_count;
                        n_state = ST_WALK;
                    end
                    alist_pkg::MODE_DROP: begin
                        if (is_empty) begin
                            n_status = alist_pkg::STAT_EMPTY;
                        end else begin
                            n_count = r_count - 1'b1;
                        end
                    end
                    alist_pkg::MODE_UPDATE: begin
                        if (pos_x >= cnt_x) begin
                            n_status = alist_pkg::STAT_BADIDX;
                        end else begin
                            o_ram_we    = 1'b1;
                            o_ram_waddr = alist_pkg::t_addr'(r_pos);
                        end
                    end
                    alist_pkg::MODE_INSERT: begin
                        if (is_full) begin
                            n_status = alist_pkg::STAT_FULL;
                        end else if (pos_x > cnt_x) begin
                            n_status = alist_pkg::STAT_BADIDX;
                        end else begin
                            // walk down from the last entry, each one moves up a slot
                            n_rd    = alist_pkg::t_addr'(cnt_x - 1'b1);
                            n_left  = alist_pkg::t_cnt'(cnt_x - pos_x);
                            n_state = ST_WALK;
                        end
                    end
                    alist_pkg::MODE_REMOVE: begin
                        if (is_empty) begin
                            n_status = alist_pkg::STAT_EMPTY;
                        end else if (pos_x >= cnt_x) begin
                            n_status = alist_pkg::STAT_BADIDX;
                        end else begin
                            // walk up from the entry after the hole, each one moves down
                            n_rd    = alist_pkg::t_addr'(pos_x + 1'b1);
                            n_left  = alist_pkg::t_cnt'(cnt_x - pos_x - 1'b1);
                            n_state = ST_WALK;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_WALK: begin
                // read issued here returns next cycle; the write trails the read by one slot
                if (issue) begin
                    n_left = r_left - 1'b1;
                    n_pend = 1'b1;
                    if (r_mode == alist_pkg::MODE_INSERT) begin
                        n_rd = r_rd - 1'b1;
                        n_wa = r_rd + 1'b1;
                    end else begin
                        n_rd = r_rd + 1'b1;
                        n_wa = r_rd - 1'b1;
                    end
                end else begin
                    n_pend = 1'b0;
                end
                if (r_mode == alist_pkg::MODE_FIND) begin
                    if (r_pend && (i_ram_rdata == r_val)) begin
                        n_found = 1'b1;
                        n_state = ST_RESULT;
                    end else if (!issue && !r_pend) begin
                        n_state = ST_RESULT;
                    end
                end else if (r_pend) begin
                    o_ram_we    = 1'b1;
                    o_ram_waddr = r_wa;
                    o_ram_wdata = i_ram_rdata;
                end else if (!issue) begin
                    n_state = ST_RESULT;
                    if (r_mode == alist_pkg::MODE_INSERT) begin
                        o_ram_we    = 1'b1;
                        o_ram_waddr = alist_pkg::t_addr'(r_pos);
                        o_ram_wdata = r_val;
                        n_count     = r_count + 1'b1;
                    end else begin
                        n_count = r_count - 1'b1;
                    end
                end
            end
            ST_RESULT: begin
                if (i_res_rdy) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_val    <= n_val;
        r_pos    <= n_pos;
        r_rd     <= n_rd;
        r_wa     <= n_wa;
        r_left   <= n_left;
        r_found  <= n_found;
        r_status <= n_status;
    end

    assign o_item_rdy   = (r_state == ST_IDLE);
    assign o_res_vld    = (r_state == ST_RESULT);
    assign o_res.status = r_status;
    assign o_res.found  = r_found;
    assign o_res.length = alist_pkg::t_len'(r_count);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= alist_pkg::t_cnt'(alist_pkg::CAPACITY))
        else $error("entry count above capacity");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == $past(r_count)) || (r_count == alist_pkg::t_cnt'($past(r_count) + 1'b1))
        || (r_count == alist_pkg::t_cnt'($past(r_count) - 1'b1)))
        else $error("entry count moved by more than one");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ram_we && (r_state == ST_WALK) && issue) |-> (o_ram_waddr != o_ram_raddr))
        else $error("shift write collides with the read in flight");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item_vld && o_item_rdy) |=> (r_state == ST_EXEC))
        else $error("accepted beat not decoded");

endmodule

/* rtl/array_list_engine.sv */
// array_list_engine: ordered list of signed words in one ram; depends on alist_pkg, alist_ctrl, alist_ram
// append, drop last, update, no-ops and errors finish in the exec state; find reads the entries in order
// from index 0 and stops at the first match, insert moves the entries from the last down to position up a slot,
// and remove moves the entries after position down a slot; each walk issues one ram read per walk cycle
// one item at a time; the next beat is taken in the cycle after the result is registered
// synchronous active-low reset empties the list (count 0); ram contents are not cleared
module array_list_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,   // mode[2:0], value[34:3], position[42:35], zero pad
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata    // status[1:0], found[2], length[10:3], zero pad
);

    alist_pkg::t_result res;
    logic               res_vld;
    logic               res_rdy;
    logic               ram_we;
    alist_pkg::t_addr   ram_waddr;
    alist_pkg::t_word   ram_wdata;
    alist_pkg::t_addr   ram_raddr;
    alist_pkg::t_word   ram_rdata;

    logic               r_out_vld;
    alist_pkg::t_result r_out;

    alist_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item_vld  (i_s_tvalid),
        .o_item_rdy  (o_s_tready),
        .i_mode      (alist_pkg::t_mode'(i_s_tdata[2:0])),
        .i_value     (alist_pkg::t_word'($signed(i_s_tdata[34:3]))),
        .i_position  (alist_pkg::t_pos'(i_s_tdata[42:35])),
        .o_res_vld   (res_vld),
        .i_res_rdy   (res_rdy),
        .o_res       (res),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    alist_ram #(
        .WIDTH (alist_pkg::WORD_W),
        .DEPTH (alist_pkg::CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign res_rdy = !r_out_vld || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_vld && res_rdy) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_vld && res_rdy) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {5'b0, r_out.length, r_out.found, r_out.status};

endmodule
